[design/keyword_token_lexer_macros.svh]
// ----------------------------------------------------------------------------
// keyword_token_lexer_macros.svh
// Assertion macros used by the lexer checker.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_LEXER_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_MACROS_SVH

// Check a property on every edge outside reset
`define KTL_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every edge, reset included
`define KTL_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/klx_pkg.sv]
// ----------------------------------------------------------------------------
// klx_pkg
// Shared constants, types and the keyword matcher of the token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package klx_pkg;

    // Sizing
    localparam int MAX_CHARS   = 7;
    localparam int LINE_BITS   = 16;
    localparam int CHARS_W     = 8 * MAX_CHARS;
    localparam int LEN_W       = $clog2(MAX_CHARS + 1);
    localparam int TEXT_W      = 56;
    localparam int TLEN_W      = 3;
    localparam int LINE_OUT_W  = 16;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int NUM_WORDS   = 9;

    // Token kinds
    localparam logic [2:0] KIND_SEP = 3'd0;
    localparam logic [2:0] KIND_OP  = 3'd1;
    localparam logic [2:0] KIND_NUM = 3'd2;
    localparam logic [2:0] KIND_KEY = 3'd3;
    localparam logic [2:0] KIND_CMP = 3'd4;
    localparam logic [2:0] KIND_ID  = 3'd5;
    localparam logic [2:0] KIND_END = 3'd6;

    // Word codes
    localparam logic [3:0] WID_NONE = 4'd0;

    // Character codes
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCENT  = 8'h25;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Request from front to back
    typedef struct packed {
        logic                 has_run;
        logic                 run_word;
        logic [CHARS_W-1:0]   run_chars;
        logic [LEN_W-1:0]     run_len;
        logic                 run_ovf;
        logic                 has_sym;
        logic [2:0]           sym_kind;
        logic [7:0]           sym_char;
        logic [LINE_BITS-1:0] line;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] word_id;
    } t_match;

    // Spelling of each reserved word, first character in the lowest byte
    function automatic logic [63:0] word_spell(input int idx);
        logic [63:0] s;
        unique case (idx)
            0:       s = 64'h0000_0000_7469_7865; // exit
            1:       s = 64'h0000_0000_0074_6e69; // int
            2:       s = 64'h0000_0000_0000_6669; // if
            3:       s = 64'h0000_0065_6c69_6877; // while
            4:       s = 64'h0000_0065_7469_7277; // write
            5:       s = 64'h0000_0000_0000_7165; // eq
            6:       s = 64'h0000_0000_0071_656e; // neq
            7:       s = 64'h0000_0000_7373_656c; // less
            8:       s = 64'h0072_6574_6165_7267; // greater
            default: s = 64'h0;
        endcase
        return s;
    endfunction

    function automatic int word_len(input int idx);
        int n;
        unique case (idx)
            0, 7:    n = 4;
            1, 6:    n = 3;
            2, 5:    n = 2;
            3, 4:    n = 5;
            8:       n = 7;
            default: n = 0;
        endcase
        return n;
    endfunction

    // Classify a word run; the first matching entry wins
    function automatic t_match match_word(input logic [CHARS_W-1:0] chars,
                                          input logic [LEN_W-1:0]   len,
                                          input logic               ovf);
        t_match m;
        m.kind    = KIND_ID;
        m.word_id = WID_NONE;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (!ovf && (64'(chars) == word_spell(i)) &&
                (len == LEN_W'(word_len(i)))) begin
                m.kind    = (i < 6) ? KIND_KEY : KIND_CMP;
                m.word_id = 4'(i + 1);
            end
        end
        return m;
    endfunction

    // Low bits of the line counter for the result port
    function automatic logic [LINE_OUT_W-1:0] line_out(input logic [LINE_BITS-1:0] x);
        logic [LINE_BITS+LINE_OUT_W-1:0] t;
        t = (LINE_BITS + LINE_OUT_W)'(x);
        return t[LINE_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/klx_front.sv]
// ----------------------------------------------------------------------------
// klx_front
// Accepts source bytes, tracks the pending run and the line counter, and
// posts one request per byte that causes tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module klx_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_end,
    input  wire logic          i_cmd_full,
    output logic               o_cmd_push,
    output klx_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        RUN_NONE = 3'b001,
        RUN_NUM  = 3'b010,
        RUN_WORD = 3'b100
    } t_run;

    t_run                          r_mode, n_mode;
    logic [klx_pkg::CHARS_W-1:0]   r_chars, n_chars;
    logic [klx_pkg::LEN_W-1:0]     r_len, n_len;
    logic                          r_ovf, n_ovf;
    logic [klx_pkg::LINE_BITS-1:0] r_line, n_line;

    logic                          accept;
    logic                          is_dig, is_let, is_sep, is_op, is_nl, cont;
    logic [klx_pkg::CHARS_W-1:0]   base_chars, app_chars;
    logic [klx_pkg::LEN_W-1:0]     base_len, app_len;
    logic                          base_ovf, app_ovf;

    assign accept = i_push && !i_cmd_full;

    // Classify the byte
    assign is_dig = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign is_let = ((i_char >= 8'h61) && (i_char <= 8'h7A)) ||
                    ((i_char >= 8'h41) && (i_char <= 8'h5A));
    assign is_sep = (i_char == klx_pkg::CH_SEMI)   || (i_char == klx_pkg::CH_COMMA)  ||
                    (i_char == klx_pkg::CH_LPAREN) || (i_char == klx_pkg::CH_RPAREN) ||
                    (i_char == klx_pkg::CH_LBRACE) || (i_char == klx_pkg::CH_RBRACE);
    assign is_op  = (i_char == klx_pkg::CH_EQUAL) || (i_char == klx_pkg::CH_PLUS)  ||
                    (i_char == klx_pkg::CH_MINUS) || (i_char == klx_pkg::CH_STAR)  ||
                    (i_char == klx_pkg::CH_SLASH) || (i_char == klx_pkg::CH_PCENT);
    assign is_nl  = (i_char == klx_pkg::CH_NL);
    assign cont   = !i_end && (((r_mode == RUN_NUM) && is_dig) ||
                               ((r_mode == RUN_WORD) && is_let));

    // Append the byte to the run, or to a fresh one
    always_comb begin
        base_chars = cont ? r_chars : '0;
        base_len   = cont ? r_len   : '0;
        base_ovf   = cont ? r_ovf   : 1'b0;
        app_chars  = base_chars;
        app_len    = base_len;
        app_ovf    = base_ovf;
        for (int i = 0; i < klx_pkg::MAX_CHARS; i++) begin
            if (base_len == klx_pkg::LEN_W'(i)) begin
                app_chars[8*i +: 8] = i_char;
            end
        end
        if (base_len < klx_pkg::LEN_W'(klx_pkg::MAX_CHARS)) begin
            app_len = base_len + 1'b1;
        end else begin
            app_chars = base_chars;
            app_ovf   = 1'b1;
        end
    end

    // Build the request and the next run state
    always_comb begin
        n_mode  = r_mode;
        n_chars = r_chars;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_line  = r_line;

        o_cmd.has_run   = !cont && (r_mode != RUN_NONE);
        o_cmd.run_word  = (r_mode == RUN_WORD);
        o_cmd.run_chars = r_chars;
        o_cmd.run_len   = r_len;
        o_cmd.run_ovf   = r_ovf;
        o_cmd.has_sym   = i_end || (is_sep || is_op);
        o_cmd.sym_kind  = i_end ? klx_pkg::KIND_END :
                          (is_sep ? klx_pkg::KIND_SEP : klx_pkg::KIND_OP);
        o_cmd.sym_char  = i_end ? 8'h00 : i_char;
        o_cmd.line      = r_line;
        o_cmd_push      = accept && (o_cmd.has_run || o_cmd.has_sym);

        if (accept) begin
            if (i_end || !(cont || is_dig || is_let)) begin
                n_mode  = RUN_NONE;
                n_chars = '0;
                n_len   = '0;
                n_ovf   = 1'b0;
                if (!i_end && is_nl && (r_line != '1)) begin
                    n_line = r_line + 1'b1;
                end
            end else begin
                if (!cont) begin
                    n_mode = is_dig ? RUN_NUM : RUN_WORD;
                end
                n_chars = app_chars;
                n_len   = app_len;
                n_ovf   = app_ovf;
            end
        end
    end

    // Hold the run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RUN_NONE;
            r_chars <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_line  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_chars <= n_chars;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_line  <= n_line;
        end
    end

endmodule

`default_nettype wire

[design/klx_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// klx_cmd_fifo
// Short request queue between the front and back of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

module klx_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire klx_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output klx_pkg::t_cmd      o_head,
    output logic               o_empty
);

    klx_pkg::t_cmd                  r_mem [klx_pkg::CMDQ_DEPTH];
    logic [klx_pkg::CMDQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [klx_pkg::CMDQ_CNT_W-1:0] r_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == klx_pkg::CMDQ_CNT_W'(klx_pkg::CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store requests
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/klx_back.sv]
// ----------------------------------------------------------------------------
// klx_back
// Expands each request into its tokens, matches reserved words and holds
// the oldest token on the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module klx_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire klx_pkg::t_cmd                    i_head,
    input  wire logic                             i_cmd_empty,
    output logic                                  o_cmd_pop,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic [2:0]                            o_kind,
    output logic [3:0]                            o_word_id,
    output logic [klx_pkg::TEXT_W-1:0]            o_text,
    output logic [klx_pkg::TLEN_W-1:0]            o_text_len,
    output logic                                  o_too_long,
    output logic [klx_pkg::LINE_OUT_W-1:0]        o_line,
    output logic                                  o_last
);

    typedef enum logic [1:0] {
        BK_RUN = 2'b01,
        BK_SYM = 2'b10
    } t_back_state;

    t_back_state                     r_state, n_state;
    logic                            r_valid;
    logic [2:0]                      r_kind, n_kind;
    logic [3:0]                      r_word_id, n_word_id;
    logic [klx_pkg::TEXT_W-1:0]      r_text, n_text;
    logic [klx_pkg::TLEN_W-1:0]      r_text_len, n_text_len;
    logic                            r_too_long, n_too_long;
    logic [klx_pkg::LINE_OUT_W-1:0]  r_line, n_line;
    logic                            r_last, n_last;

    logic                            load, emit_run;
    klx_pkg::t_match                 wmatch;

    assign load     = !i_cmd_empty && (!r_valid || i_pop);
    assign emit_run = i_head.has_run && (r_state == BK_RUN);
    assign wmatch   = klx_pkg::match_word(i_head.run_chars, i_head.run_len,
                                          i_head.run_ovf);

    // Select the next token from the head request
    always_comb begin
        n_line = klx_pkg::line_out(i_head.line);
        if (emit_run) begin
            n_kind     = i_head.run_word ? wmatch.kind    : klx_pkg::KIND_NUM;
            n_word_id  = i_head.run_word ? wmatch.word_id : klx_pkg::WID_NONE;
            n_text     = klx_pkg::TEXT_W'(i_head.run_chars);
            n_text_len = klx_pkg::TLEN_W'(i_head.run_len);
            n_too_long = i_head.run_ovf;
            n_last     = !i_head.has_sym;
        end else begin
            n_kind     = i_head.sym_kind;
            n_word_id  = klx_pkg::WID_NONE;
            n_text     = klx_pkg::TEXT_W'(i_head.sym_char);
            n_text_len = (i_head.sym_kind == klx_pkg::KIND_END) ?
                         klx_pkg::TLEN_W'(0) : klx_pkg::TLEN_W'(1);
            n_too_long = 1'b0;
            n_last     = 1'b1;
        end
    end

    // Drop the request once its last token is out
    always_comb begin
        o_cmd_pop = 1'b0;
        n_state   = r_state;
        if (load) begin
            if (emit_run && i_head.has_sym) begin
                n_state = BK_SYM;
            end else begin
                n_state   = BK_RUN;
                o_cmd_pop = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= n_kind;
            r_word_id  <= n_word_id;
            r_text     <= n_text;
            r_text_len <= n_text_len;
            r_too_long <= n_too_long;
            r_line     <= n_line;
            r_last     <= n_last;
        end
    end

    assign o_empty    = !r_valid;
    assign o_kind     = r_kind;
    assign o_word_id  = r_word_id;
    assign o_text     = r_text;
    assign o_text_len = r_text_len;
    assign o_too_long = r_too_long;
    assign o_line     = r_line;
    assign o_last     = r_last;

endmodule

`default_nettype wire

[design/keyword_token_lexer.sv]
// A token reaches the result ports through the request queue and the result register;
// the second token of a byte follows once the first has been popped.
// Throughput: one byte per cycle unless the queue is full; the back emits one token per
// cycle while results are popped; the four-entry request queue absorbs two-token bytes.
// Reset (synchronous, active low) clears the run, the line counter and the request
// queue, and empties the result register.
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Streaming lexer: bytes in, classified tokens out, queue handshake on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_lexer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_char_in,
    input  wire logic                              i_end_of_text,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [2:0]                             o_kind,
    output logic [3:0]                             o_word_id,
    output logic [klx_pkg::TEXT_W-1:0]             o_text,
    output logic [klx_pkg::TLEN_W-1:0]             o_text_len,
    output logic                                   o_too_long,
    output logic [klx_pkg::LINE_OUT_W-1:0]         o_line,
    output logic                                   o_last
);

    klx_pkg::t_cmd front_cmd, head_cmd;
    logic          cmd_push, cmd_full, cmd_pop, cmd_empty;

    assign full = cmd_full;

    // Front: accept and classify bytes
    klx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_char     (i_char_in),
        .i_end      (i_end_of_text),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    // Request queue
    klx_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_head  (head_cmd),
        .o_empty (cmd_empty)
    );

    // Back: emit tokens
    klx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_word_id   (o_word_id),
        .o_text      (o_text),
        .o_text_len  (o_text_len),
        .o_too_long  (o_too_long),
        .o_line      (o_line),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

[design/klx_checker.sv]
// ----------------------------------------------------------------------------
// klx_checker
// Port-level checks of the token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyword_token_lexer_macros.svh"

module klx_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic [2:0]                        o_kind,
    input wire logic [3:0]                        o_word_id,
    input wire logic [klx_pkg::TEXT_W-1:0]        o_text,
    input wire logic [klx_pkg::TLEN_W-1:0]        o_text_len,
    input wire logic                              o_too_long,
    input wire logic                              o_last
);

    // No token survives reset
    `KTL_ASSERT_ALL(a_reset_empty, i_clk, !i_rst_n |=> empty, "token after reset")

    // Hold a waiting token
    `KTL_ASSERT_ON(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_text) && $stable(o_last)), "waiting token changed")

    // End token carries no text and closes its request
    `KTL_ASSERT_ON(a_end_tok, i_clk, i_rst_n, (!empty && o_kind == klx_pkg::KIND_END) |-> (o_text == '0 && o_text_len == '0 && o_last), "bad end token")

    // Word code only on keywords and comparisons
    `KTL_ASSERT_ON(a_word_id, i_clk, i_rst_n, (!empty && o_word_id != klx_pkg::WID_NONE) |-> (o_kind == klx_pkg::KIND_KEY || o_kind == klx_pkg::KIND_CMP), "word code on wrong kind")

    // Symbols are single characters that end their request
    `KTL_ASSERT_ON(a_symbol, i_clk, i_rst_n, (!empty && (o_kind == klx_pkg::KIND_SEP || o_kind == klx_pkg::KIND_OP)) |-> (o_text_len == 3'd1 && o_last && !o_too_long), "bad symbol token")

endmodule

bind keyword_token_lexer klx_checker u_klx_checker (.*);

`default_nettype wire

[sim/keyword_token_lexer_checker.sv]
// ----------------------------------------------------------------------------
// keyword_token_lexer_checker
// Watches both queue ports of the lexer. Each accepted byte is run through a
// local lexer model, which queues the tokens it should produce. Each popped
// token is compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyword_token_lexer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [7:0]                     i_char_in,
    input  logic                           i_end_of_text,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [2:0]                     i_kind,
    input  logic [3:0]                     i_word_id,
    input  logic [klx_pkg::TEXT_W-1:0]     i_text,
    input  logic [klx_pkg::TLEN_W-1:0]     i_text_len,
    input  logic                           i_too_long,
    input  logic [klx_pkg::LINE_OUT_W-1:0] i_line,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef enum logic [1:0] {RUN_IDLE, RUN_DIGITS, RUN_LETTERS} t_run;

    typedef enum logic [3:0] {
        W_NONE, W_EXIT, W_INT, W_IF, W_WHILE, W_WRITE, W_EQ, W_NEQ, W_LESS, W_GREATER
    } t_word;

    typedef struct packed {
        logic [2:0]                     kind;
        logic [3:0]                     word_id;
        logic [klx_pkg::TEXT_W-1:0]     text;
        logic [klx_pkg::TLEN_W-1:0]     text_len;
        logic                           too_long;
        logic [klx_pkg::LINE_OUT_W-1:0] line;
        logic                           last;
    } t_token;

    // Lexer model state
    t_run                       run_kind;
    logic [klx_pkg::TEXT_W-1:0] run_text;
    logic [2:0]                 run_len;
    logic                       run_over;
    logic [15:0]                line_count;

    t_token expected_tokens[$];
    int     fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic string spelling_of(input t_word w);
        case (w)
            W_EXIT:    return "exit";
            W_INT:     return "int";
            W_IF:      return "if";
            W_WHILE:   return "while";
            W_WRITE:   return "write";
            W_EQ:      return "eq";
            W_NEQ:     return "neq";
            W_LESS:    return "less";
            W_GREATER: return "greater";
            default:   return "";
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic t_token make_token(input logic [2:0] kind, input t_word wid,
                                          input logic [klx_pkg::TEXT_W-1:0] text,
                                          input logic [2:0] len, input logic over);
        t_token t;
        t.kind     = kind;
        t.word_id  = wid;
        t.text     = text;
        t.text_len = len;
        t.too_long = over;
        t.line     = line_count;
        t.last     = 1'b0;
        return t;
    endfunction

    // Classify the pending run, build its token and clear the run
    function automatic t_token close_run();
        t_token                     t;
        logic [2:0]                 kind;
        t_word                      wid;
        string                      s;
        logic [klx_pkg::TEXT_W-1:0] packed_word;
        kind = klx_pkg::KIND_NUM;
        wid  = W_NONE;
        if (run_kind == RUN_LETTERS) begin
            kind = klx_pkg::KIND_ID;
            if (!run_over) begin
                for (int i = int'(W_EXIT); i <= int'(W_GREATER); i++) begin
                    s = spelling_of(t_word'(i));
                    packed_word = '0;
                    for (int k = 0; k < s.len(); k++)
                        packed_word[8*k +: 8] = s[k];
                    if (wid == W_NONE && s.len() == int'(run_len) &&
                        packed_word == run_text) begin
                        wid  = t_word'(i);
                        kind = (wid <= W_EQ) ? klx_pkg::KIND_KEY : klx_pkg::KIND_CMP;
                    end
                end
            end
        end
        t = make_token(kind, wid, run_text, run_len, run_over);
        run_kind = RUN_IDLE;
        run_text = '0;
        run_len  = '0;
        run_over = 1'b0;
        return t;
    endfunction

    // Keep up to seven characters, flag the rest as dropped
    function automatic void add_char(input logic [7:0] c);
        if (run_len < 3'd7) begin
            run_text[8*run_len +: 8] = c;
            run_len++;
        end else begin
            run_over = 1'b1;
        end
    endfunction

    // Lex one accepted request and queue the tokens it produces
    task automatic lex_request(input logic [7:0] c, input logic eot);
        t_token made[2];
        int     n;
        logic   cont;
        n = 0;
        if (eot) begin
            if (run_kind != RUN_IDLE) begin
                made[n] = close_run();
                n++;
            end
            made[n] = make_token(klx_pkg::KIND_END, W_NONE, '0, '0, 1'b0);
            n++;
        end else begin
            cont = (run_kind == RUN_DIGITS && is_digit(c)) ||
                   (run_kind == RUN_LETTERS && is_letter(c));
            if (cont) begin
                add_char(c);
            end else begin
                if (run_kind != RUN_IDLE) begin
                    made[n] = close_run();
                    n++;
                end
                if (is_digit(c)) begin
                    run_kind = RUN_DIGITS;
                    add_char(c);
                end else if (is_letter(c)) begin
                    run_kind = RUN_LETTERS;
                    add_char(c);
                end else if (c == klx_pkg::CH_SEMI || c == klx_pkg::CH_COMMA ||
                             c == klx_pkg::CH_LPAREN || c == klx_pkg::CH_RPAREN ||
                             c == klx_pkg::CH_LBRACE || c == klx_pkg::CH_RBRACE) begin
                    made[n] = make_token(klx_pkg::KIND_SEP, W_NONE,
                                         klx_pkg::TEXT_W'(c), 3'd1, 1'b0);
                    n++;
                end else if (c == klx_pkg::CH_EQUAL || c == klx_pkg::CH_PLUS ||
                             c == klx_pkg::CH_MINUS || c == klx_pkg::CH_STAR ||
                             c == klx_pkg::CH_SLASH || c == klx_pkg::CH_PCENT) begin
                    made[n] = make_token(klx_pkg::KIND_OP, W_NONE,
                                         klx_pkg::TEXT_W'(c), 3'd1, 1'b0);
                    n++;
                end else if (c == klx_pkg::CH_NL && line_count != 16'hFFFF) begin
                    line_count++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            expected_tokens.push_back(made[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    // Compare a popped token with the oldest expected one
    task automatic check_token();
        t_token want;
        if (expected_tokens.size() == 0) begin
            $error("token popped with none expected: kind %0d text 0x%0h", i_kind, i_text);
            fail_total++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 64'(want.kind), 64'(i_kind));
            check_field("word_id", 64'(want.word_id), 64'(i_word_id));
            check_field("text", 64'(want.text), 64'(i_text));
            check_field("text_len", 64'(want.text_len), 64'(i_text_len));
            check_field("too_long", 64'(want.too_long), 64'(i_too_long));
            check_field("line", 64'(want.line), 64'(i_line));
            check_field("last", 64'(want.last), 64'(i_last));
        end
    endtask

    // Sample both ports at the edge; requests go in before results come out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_kind   = RUN_IDLE;
            run_text   = '0;
            run_len    = '0;
            run_over   = 1'b0;
            line_count = '0;
            expected_tokens.delete();
        end else begin
            if (i_push && !i_full)
                lex_request(i_char_in, i_end_of_text);
            if (i_pop && !i_empty)
                check_token();
        end
        o_pending <= expected_tokens.size();
    end

endmodule

[sim/tb_keyword_token_lexer.sv]
// ----------------------------------------------------------------------------
// tb_keyword_token_lexer
// Drives source bytes into the lexer: a short directed text, then random
// token streams with noise in phases of differing idle pressure, then a
// closing run, symbol and end. The checker beside the block predicts and
// compares every token; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyword_token_lexer;

    localparam int LIMIT = 1000000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic [7:0]                     char_in     = 8'h00;
    logic                           end_of_text = 1'b0;
    logic                           pop         = 1'b0;
    wire                            full;
    wire                            empty;
    wire [2:0]                      tok_kind;
    wire [3:0]                      tok_word_id;
    wire [klx_pkg::TEXT_W-1:0]      tok_text;
    wire [klx_pkg::TLEN_W-1:0]      tok_text_len;
    wire                            tok_too_long;
    wire [klx_pkg::LINE_OUT_W-1:0]  tok_line;
    wire                            tok_last;
    int                             fail_count;
    int                             pending;

    int   cycles     = 0;
    int   sent_items = 0;
    int   pop_hold   = 0;
    logic quiet      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    keyword_token_lexer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_in     (char_in),
        .i_end_of_text (end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (tok_kind),
        .o_word_id     (tok_word_id),
        .o_text        (tok_text),
        .o_text_len    (tok_text_len),
        .o_too_long    (tok_too_long),
        .o_line        (tok_line),
        .o_last        (tok_last)
    );

    keyword_token_lexer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_char_in     (char_in),
        .i_end_of_text (end_of_text),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_kind        (tok_kind),
        .i_word_id     (tok_word_id),
        .i_text        (tok_text),
        .i_text_len    (tok_text_len),
        .i_too_long    (tok_too_long),
        .i_line        (tok_line),
        .i_last        (tok_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("keyword_token_lexer test failed");
            $finish;
        end
    end

    // Mostly short idle gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // Stall the result side at random unless the phase runs flat out
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!quiet && $urandom_range(0, 99) < 30) begin
            pop      <= 1'b0;
            pop_hold <= idle_len() - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // Offer one request, idling first, and hold it until taken
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        char_in     <= c;
        end_of_text <= eot;
        do @(posedge i_clk); while (full);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Hold the sender until every expected token has come out
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic string reserved_word(input int idx);
        case (idx)
            0:       return "exit";
            1:       return "int";
            2:       return "if";
            3:       return "while";
            4:       return "write";
            5:       return "eq";
            6:       return "neq";
            7:       return "less";
            default: return "greater";
        endcase
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(0, 1) != 0)
            return 8'("a" + $urandom_range(0, 25));
        else
            return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic int run_len_pick();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    endfunction

    // Send one random piece of source text: mostly well formed, some noise
    task automatic send_piece();
        string      s;
        string      tail;
        int         r;
        int         v;
        int         n;
        logic [7:0] sep_set [6];
        logic [7:0] op_set  [6];
        sep_set = '{klx_pkg::CH_SEMI, klx_pkg::CH_COMMA, klx_pkg::CH_LPAREN,
                    klx_pkg::CH_RPAREN, klx_pkg::CH_LBRACE, klx_pkg::CH_RBRACE};
        op_set  = '{klx_pkg::CH_EQUAL, klx_pkg::CH_PLUS, klx_pkg::CH_MINUS,
                    klx_pkg::CH_STAR, klx_pkg::CH_SLASH, klx_pkg::CH_PCENT};
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // reserved word, sometimes bent into a near miss
            s = reserved_word($urandom_range(0, 8));
            v = $urandom_range(0, 99);
            if (v >= 60 && v < 75) begin
                s[0] = s[0] - 8'd32;
            end else if (v >= 75 && v < 90) begin
                tail    = "a";
                tail[0] = any_letter();
                s       = {s, tail};
            end else if (v >= 90 && s.len() > 1) begin
                s = s.substr(0, s.len() - 2);
            end
            send_text(s);
        end else if (r < 35) begin
            n = run_len_pick();
            for (int i = 0; i < n; i++)
                send_byte(any_letter(), 1'b0);
        end else if (r < 50) begin
            n = run_len_pick();
            for (int i = 0; i < n; i++)
                send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (r < 62) begin
            send_byte(sep_set[$urandom_range(0, 5)], 1'b0);
        end else if (r < 74) begin
            send_byte(op_set[$urandom_range(0, 5)], 1'b0);
        end else if (r < 82) begin
            send_byte(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h09, 1'b0);
        end else if (r < 88) begin
            send_byte(klx_pkg::CH_NL, 1'b0);
        end else if (r < 96) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic random_phase(input int count, input logic flat_out);
        int stop_at;
        quiet   = flat_out;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
            send_piece();
        drain();
        quiet = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: keyword then separator, run switch, newline ending a run,
        // overlong word then operator, comparison flushed by end, skipped
        // bytes at both extremes, bare end with an all-ones byte
        send_text("while(");
        send_text("9z\n");
        send_text("greaterx-");
        send_text("neq");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // Random token streams under normal, flat-out and normal idling
        random_phase(500, 1'b0);
        random_phase(300, 1'b1);
        random_phase(620, 1'b0);

        // Close with a run switch, a separator and an end at full rate
        quiet = 1'b1;
        send_text("ab7;");
        send_byte(8'h41, 1'b1);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("keyword_token_lexer test passed");
        else
            $display("keyword_token_lexer test failed");
        $finish;
    end

endmodule
